// ===== sv/rmts_pkg.sv =====
package rmts_pkg;

	localparam logic [1:0] OP_REGISTER   = 2'd0;
	localparam logic [1:0] OP_YIELD      = 2'd1;
	localparam logic [1:0] OP_DEREGISTER = 2'd2;
	localparam logic [1:0] OP_TICK       = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVER_UTIL = 3'd1;
	localparam logic [2:0] ST_ZERO_PER  = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_UNKNOWN   = 3'd4;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_READY = 2'd1;
	localparam logic [1:0] MODE_RUN   = 2'd2;
	localparam logic [1:0] MODE_SLEEP = 2'd3;

	localparam logic [13:0] UTIL_LIMIT_RESET = 14'd6930;

	typedef struct packed {
		logic [1:0]  operation;
		logic [21:0] task_id;
		logic [31:0] task_period;
		logic [31:0] task_runtime;
		logic [31:0] now_ms;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        running_valid;
		logic [21:0] running_id;
		logic        switched;
		logic [13:0] total_utilization;
	} rsp_t;

	// one table entry
	typedef struct packed {
		logic [21:0] id;
		logic [31:0] period;
		logic [13:0] share;
		logic [1:0]  mode;
		logic [31:0] start_ms;
		logic [31:0] wake_time;
	} slot_t;

endpackage

// ===== sv/rmts_div.sv =====
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
module rmts_div import rmts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [47:0] quotient
);
	logic [32:0] rem_q;
	logic [47:0] quo_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[47]} - {1'b0, dvs_q};
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule

// ===== sv/rmts_mem.sv =====
// Slot table: one write port, one read port, registered read data.
module rmts_mem import rmts_pkg::*; #(
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  slot_t         wdata,
	input  logic [AW-1:0] raddr,
	output slot_t         rdata
);
	slot_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/rate_monotonic_task_scheduler_unit.sv =====
// Rate-monotonic task scheduler.
// Input channel cmd (cmd_valid/cmd_ready) carries one command item; output
// channel rsp (rsp_valid/rsp_ready) returns exactly one result item for it.
// cfg_we/cfg_wdata writes the utilization limit (reset 6930); the user must
// write it only when idle, the block does not enforce this. Slot state sits
// in a one-port-read synchronous table; the controller walks it slot by slot.
// Per command: a lookup pass over MAX_TASKS slots (read, then check, per
// slot), an update write, then a dispatch pass (read, then check, per slot),
// a read of the running slot and up to two mode writes. Register with a
// nonzero period adds a share division before the update write.
// The result is held in an output register; cmd_ready stays low while a
// command is worked and while its result waits, so a stalled receiver holds
// off the next command. One command is in flight at a time.
// Reset clears valid bits, utilization sum and the running task; table
// payload needs no clearing.
module rate_monotonic_task_scheduler_unit import rmts_pkg::*; #(
	parameter int MAX_TASKS = 16,
	parameter int SHARE_SCALE = 10000
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [13:0] cfg_wdata
);
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = AW + 1;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SRD   = 4'd1;
	localparam logic [3:0] S_SCHK  = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_APPLY = 4'd4;
	localparam logic [3:0] S_DRD   = 4'd5;
	localparam logic [3:0] S_DCHK  = 4'd6;
	localparam logic [3:0] S_RRD   = 4'd7;
	localparam logic [3:0] S_RCHK  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0]  state_q;
	cmd_t        cmd_q;
	logic [13:0] limit_q;
	logic [13:0] total_q;
	logic [MAX_TASKS-1:0] valid_q;
	logic        run_v_q;
	logic [AW-1:0] run_s_q;
	logic        prev_v_q;
	logic [AW-1:0] prev_s_q;
	logic [CW-1:0] idx_q;
	logic        found_q;
	logic [AW-1:0] hit_q;
	slot_t       hit_ent_q;
	logic        best_v_q;
	logic [AW-1:0] best_q;
	logic [31:0] best_per_q;
	logic [31:0] run_per_q;
	logic [1:0]  run_mode_q;
	logic [21:0] run_id_q;
	logic [2:0]  status_q;
	logic        free_v_q;
	logic [AW-1:0] free_q;
	logic [47:0] share_q;
	rsp_t        rsp_q;
	logic        rsp_v_q;

	logic        we;
	logic [AW-1:0] waddr, raddr;
	slot_t       wdata, rdata;
	logic        div_start, div_done;
	logic [47:0] div_quo;
	logic [AW-1:0] idx_a;

	assign idx_a = idx_q[AW-1:0];

	rmts_mem #(.AW(AW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	rmts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({16'd0, cmd_q.task_runtime} * 48'(SHARE_SCALE)),
		.divisor(cmd_q.task_period), .done(div_done), .quotient(div_quo)
	);

	assign cmd_ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp_valid = rsp_v_q;
	assign rsp = rsp_q;
	assign raddr = (state_q == S_RRD || state_q == S_RCHK) ? run_s_q : idx_a;

	// yield timing from the hit entry
	logic [31:0] elapsed, sleep_t;
	assign elapsed = (hit_ent_q.start_ms == 32'd0) ? 32'd0
		: cmd_q.now_ms - hit_ent_q.start_ms;
	assign sleep_t = (elapsed >= hit_ent_q.period) ? 32'd0 : hit_ent_q.period - elapsed;

	logic [14:0] sum_share;
	assign sum_share = {1'b0, total_q} + 15'(share_q[13:0]);
	logic share_big;
	assign share_big = (share_q[47:15] != '0) || ({1'b0, share_q[14:0]} + {2'b0, total_q}
		>= {2'b0, limit_q});

	// command status, valid in the apply state
	logic [2:0] status_d;
	always_comb begin
		status_d = ST_OK;
		case (cmd_q.operation)
			OP_REGISTER: begin
				if (cmd_q.task_period == '0)
					status_d = ST_ZERO_PER;
				else if (share_big)
					status_d = ST_OVER_UTIL;
				else if (!free_v_q)
					status_d = ST_FULL;
			end
			OP_YIELD, OP_DEREGISTER: begin
				if (!found_q)
					status_d = ST_UNKNOWN;
			end
			default: ;
		endcase
	end

	// table writes
	always_comb begin
		we = 1'b0;
		waddr = idx_a;
		wdata = rdata;
		case (state_q)
			S_SCHK: begin
				// tick: wake due sleepers in place
				if (cmd_q.operation == OP_TICK && valid_q[idx_a] &&
					rdata.mode == MODE_SLEEP &&
					!(cmd_q.now_ms - rdata.wake_time >= 32'h8000_0000)) begin
					we = 1'b1;
					wdata.mode = MODE_READY;
					wdata.start_ms = cmd_q.now_ms;
				end
			end
			S_APPLY: begin
				if (cmd_q.operation == OP_REGISTER && status_d == ST_OK) begin
					we = 1'b1;
					waddr = free_q;
					wdata.id = cmd_q.task_id;
					wdata.period = cmd_q.task_period;
					wdata.share = share_q[13:0];
					wdata.mode = MODE_IDLE;
					wdata.start_ms = '0;
					wdata.wake_time = '0;
				end else if (cmd_q.operation == OP_YIELD && found_q && sleep_t != '0) begin
					we = 1'b1;
					waddr = hit_q;
					wdata = hit_ent_q;
					wdata.mode = MODE_SLEEP;
					wdata.wake_time = cmd_q.now_ms + sleep_t;
				end
			end
			S_RCHK: begin
				// preempted task goes back to ready
				we = 1'b1;
				waddr = run_s_q;
				wdata.mode = MODE_READY;
				if (!(best_v_q && run_v_q && rdata.mode == MODE_RUN &&
					best_per_q < rdata.period))
					we = 1'b0;
			end
			S_DONE: begin
				if (best_v_q && (!run_v_q || best_per_q < run_per_q)) begin
					we = 1'b1;
					waddr = best_q;
					wdata = hit_ent_q;
					wdata.mode = MODE_RUN;
				end
			end
			default: ;
		endcase
	end

	assign div_start = (state_q == S_SCHK) && (cmd_q.operation == OP_REGISTER) &&
		(idx_q == CW'(MAX_TASKS - 1)) && (cmd_q.task_period != '0);

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= UTIL_LIMIT_RESET;
			total_q <= '0;
			valid_q <= '0;
			run_v_q <= 1'b0;
			run_s_q <= '0;
			rsp_v_q <= 1'b0;
		end else begin
			if (cfg_we)
				limit_q <= cfg_wdata;
			if (rsp_v_q && rsp_ready)
				rsp_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						cmd_q <= cmd;
						prev_v_q <= run_v_q;
						prev_s_q <= run_s_q;
						idx_q <= '0;
						found_q <= 1'b0;
						free_v_q <= 1'b0;
						state_q <= S_SRD;
					end
				end
				S_SRD: state_q <= S_SCHK;
				S_SCHK: begin
					// lowest matching id and lowest free slot
					if (valid_q[idx_a] && rdata.id == cmd_q.task_id && !found_q) begin
						found_q <= 1'b1;
						hit_q <= idx_a;
						hit_ent_q <= rdata;
					end
					if (!valid_q[idx_a] && !free_v_q) begin
						free_v_q <= 1'b1;
						free_q <= idx_a;
					end
					if (idx_q == CW'(MAX_TASKS - 1)) begin
						idx_q <= '0;
						if (cmd_q.operation == OP_REGISTER && cmd_q.task_period != '0)
							state_q <= S_DIV;
						else
							state_q <= S_APPLY;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SRD;
					end
				end
				S_DIV: begin
					if (div_done) begin
						share_q <= div_quo;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					status_q <= status_d;
					state_q <= S_DRD;
					idx_q <= '0;
					best_v_q <= 1'b0;
				end
				S_DRD: begin
					// side effects of the command settle on entry
					if (idx_q == '0) begin
						if (cmd_q.operation == OP_REGISTER && status_q == ST_OK) begin
							valid_q[free_q] <= 1'b1;
							total_q <= sum_share[13:0];
						end
						if (cmd_q.operation == OP_YIELD && found_q && sleep_t != '0 &&
							run_v_q && run_s_q == hit_q)
							run_v_q <= 1'b0;
						if (cmd_q.operation == OP_DEREGISTER && found_q) begin
							valid_q[hit_q] <= 1'b0;
							total_q <= (total_q >= hit_ent_q.share) ?
								total_q - hit_ent_q.share : 14'd0;
							if (run_v_q && run_s_q == hit_q)
								run_v_q <= 1'b0;
						end
					end
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (valid_q[idx_a] && rdata.mode == MODE_READY &&
						(!best_v_q || rdata.period < best_per_q)) begin
						best_v_q <= 1'b1;
						best_q <= idx_a;
						best_per_q <= rdata.period;
						hit_ent_q <= rdata;
					end
					if (idx_q == CW'(MAX_TASKS - 1))
						state_q <= S_RRD;
					else begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_DRD;
					end
				end
				S_RRD: state_q <= S_RCHK;
				S_RCHK: begin
					run_per_q <= rdata.period;
					run_mode_q <= rdata.mode;
					run_id_q <= rdata.id;
					state_q <= S_DONE;
				end
				S_DONE: begin
					rsp_q.status <= status_q;
					rsp_q.total_utilization <= total_q;
					if (best_v_q && (!run_v_q || best_per_q < run_per_q)) begin
						run_v_q <= 1'b1;
						run_s_q <= best_q;
						rsp_q.running_valid <= 1'b1;
						rsp_q.running_id <= hit_ent_q.id;
						rsp_q.switched <= !prev_v_q || (prev_s_q != best_q);
					end else begin
						rsp_q.running_valid <= run_v_q;
						rsp_q.running_id <= run_v_q ? run_id_q : 22'd0;
						rsp_q.switched <= (prev_v_q != run_v_q) ||
							(run_v_q && prev_s_q != run_s_q);
					end
					rsp_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== test/tb_rate_monotonic_task_scheduler_unit.sv =====
`timescale 1ns / 1ps

import rmts_pkg::*;

// Shadow scheduler: tracks the task table and predicts each result item.
class sched_scoreboard;
	logic [13:0] util_limit;
	bit          used [16];
	logic [21:0] ids [16];
	logic [31:0] periods [16];
	logic [13:0] shares [16];
	logic [1:0]  modes [16];
	logic [31:0] starts [16];
	logic [31:0] wakes [16];
	logic [13:0] share_sum;
	bit          run_on;
	int          run_slot;
	rsp_t        expected_rsp [$];
	int          errors;

	function new();
		util_limit = UTIL_LIMIT_RESET;
		for (int i = 0; i < 16; i++) used[i] = 0;
		share_sum = '0;
		run_on = 0;
		run_slot = 0;
		errors = 0;
	endfunction

	function int lookup(logic [21:0] id);
		for (int i = 0; i < 16; i++)
			if (used[i] && ids[i] == id) return i;
		return -1;
	endfunction

	function int pending();
		return expected_rsp.size();
	endfunction

	// apply one accepted command item and queue its result
	function void note_command(cmd_t c);
		logic [2:0]  st;
		bit          prev_on;
		int          prev_slot;
		int          s;
		int          best;
		logic [63:0] ratio;
		logic [31:0] elapsed;
		logic [31:0] nap;
		rsp_t        r;
		st = ST_OK;
		prev_on = run_on;
		prev_slot = run_slot;
		case (c.operation)
			OP_REGISTER: begin
				if (c.task_period == 0) begin
					st = ST_ZERO_PER;
				end else begin
					ratio = ({32'd0, c.task_runtime} * 64'd10000) / {32'd0, c.task_period};
					s = -1;
					for (int i = 0; i < 16; i++)
						if (!used[i] && s < 0) s = i;
					if ({50'd0, share_sum} + ratio >= {50'd0, util_limit}) st = ST_OVER_UTIL;
					else if (s < 0) st = ST_FULL;
					else begin
						used[s] = 1;
						ids[s] = c.task_id;
						periods[s] = c.task_period;
						shares[s] = ratio[13:0];
						modes[s] = MODE_IDLE;
						starts[s] = '0;
						wakes[s] = '0;
						share_sum = share_sum + ratio[13:0];
					end
				end
			end
			OP_YIELD: begin
				s = lookup(c.task_id);
				if (s < 0) begin
					st = ST_UNKNOWN;
				end else begin
					elapsed = (starts[s] == 0) ? 32'd0 : c.now_ms - starts[s];
					nap = (elapsed >= periods[s]) ? 32'd0 : periods[s] - elapsed;
					if (nap != 0) begin
						wakes[s] = c.now_ms + nap;
						modes[s] = MODE_SLEEP;
						if (run_on && run_slot == s) run_on = 0;
					end
				end
			end
			OP_DEREGISTER: begin
				s = lookup(c.task_id);
				if (s < 0) begin
					st = ST_UNKNOWN;
				end else begin
					share_sum = (share_sum >= shares[s]) ? share_sum - shares[s] : 14'd0;
					used[s] = 0;
					if (run_on && run_slot == s) run_on = 0;
				end
			end
			default: begin
				// wake sleepers whose wake time has passed (half-range compare)
				for (int i = 0; i < 16; i++)
					if (used[i] && modes[i] == MODE_SLEEP &&
						((c.now_ms - wakes[i]) < 32'h8000_0000)) begin
						modes[i] = MODE_READY;
						starts[i] = c.now_ms;
					end
			end
		endcase
		// rate-monotonic pick, lowest slot wins ties
		best = -1;
		for (int i = 0; i < 16; i++)
			if (used[i] && modes[i] == MODE_READY && (best < 0 || periods[i] < periods[best]))
				best = i;
		if (best >= 0 && (!run_on || periods[best] < periods[run_slot])) begin
			if (run_on && modes[run_slot] == MODE_RUN) modes[run_slot] = MODE_READY;
			modes[best] = MODE_RUN;
			run_slot = best;
			run_on = 1;
		end
		r.status = st;
		r.running_valid = run_on;
		r.running_id = run_on ? ids[run_slot] : 22'd0;
		r.switched = (prev_on != run_on) || (run_on && prev_slot != run_slot);
		r.total_utilization = share_sum;
		expected_rsp.push_back(r);
	endfunction

	function void check_response(rsp_t got);
		rsp_t want;
		if (expected_rsp.size() == 0) begin
			$display("%0t: unexpected result item %h", $time, got);
			errors++;
			return;
		end
		want = expected_rsp.pop_front();
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			errors++;
		end
		if (got.running_valid !== want.running_valid) begin
			$display("%0t: running_valid expected %0d actual %0d", $time,
				want.running_valid, got.running_valid);
			errors++;
		end
		if (got.running_id !== want.running_id) begin
			$display("%0t: running_id expected %h actual %h", $time,
				want.running_id, got.running_id);
			errors++;
		end
		if (got.switched !== want.switched) begin
			$display("%0t: switched expected %0d actual %0d", $time, want.switched, got.switched);
			errors++;
		end
		if (got.total_utilization !== want.total_utilization) begin
			$display("%0t: total_utilization expected %0d actual %0d", $time,
				want.total_utilization, got.total_utilization);
			errors++;
		end
	endfunction
endclass

module tb_rate_monotonic_task_scheduler_unit;
	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        rsp_valid;
	logic        rsp_ready;
	rsp_t        rsp;
	logic        cfg_we;
	logic [13:0] cfg_wdata;

	sched_scoreboard sb;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          quiet_cycles;
	logic [31:0] sim_ms;

	rate_monotonic_task_scheduler_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #2 clk = ~clk;

	function automatic cmd_t mk(logic [1:0] op, logic [21:0] id, logic [31:0] per,
		logic [31:0] run, logic [31:0] now);
		cmd_t c;
		c.operation = op;
		c.task_id = id;
		c.task_period = per;
		c.task_runtime = run;
		c.now_ms = now;
		return c;
	endfunction

	// random command: mostly plausible traffic on a small id pool, some noise
	function automatic cmd_t rand_cmd();
		cmd_t        c;
		int          pick;
		logic [21:0] id;
		logic [31:0] per;
		pick = $urandom_range(99);
		if ($urandom_range(99) < 5) sim_ms = $urandom;
		else sim_ms = sim_ms + $urandom_range(0, 60);
		id = ($urandom_range(19) == 0) ? 22'h3FFFFF : 22'($urandom_range(0, 11));
		if (pick < 8) begin
			c = mk(2'($urandom), 22'($urandom), $urandom, $urandom, $urandom);
		end else if (pick < 38) begin
			per = ($urandom_range(29) == 0) ? 32'd0 : 32'($urandom_range(1, 300));
			if ($urandom_range(7) == 0) c = mk(OP_REGISTER, id, per, $urandom_range(0, 300), sim_ms);
			else c = mk(OP_REGISTER, id, per, per / $urandom_range(20, 200), sim_ms);
		end else if (pick < 66) begin
			c = mk(OP_YIELD, id, $urandom, $urandom, sim_ms);
		end else if (pick < 76) begin
			c = mk(OP_DEREGISTER, id, $urandom, $urandom, sim_ms);
		end else begin
			c = mk(OP_TICK, id, $urandom, $urandom, sim_ms);
		end
		return c;
	endfunction

	// offer one command item; valid stays high from here until the next call
	task automatic send_cmd(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!cmd_ready);
		sb.note_command(c);
	endtask

	// hold off until all results are back, then write the limit register
	task automatic write_limit(logic [13:0] value);
		cmd_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.util_limit = value;
	endtask

	// result side: random stalls, check every accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) sb.check_response(rsp);
			rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 20000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		quiet_cycles = 0;
		sim_ms = 32'd5000;
		send_idle_pct = 37;
		recv_stall_pct = 86;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: status codes, extremes, sleep timing, wraparound wake
		send_cmd(mk(OP_REGISTER, 22'd0, 32'd0, 32'd10, 32'd0));
		send_cmd(mk(OP_REGISTER, 22'd1, 32'd100, 32'd100, 32'd0));
		send_cmd(mk(OP_REGISTER, 22'h3FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
		send_cmd(mk(OP_REGISTER, 22'h3FFFFF, 32'hFFFFFFFF, 32'd0, 32'hFFFFFFFF));
		send_cmd(mk(OP_REGISTER, 22'd5, 32'd10, 32'd1, 32'd0));
		send_cmd(mk(OP_REGISTER, 22'd5, 32'd20, 32'd2, 32'd0));
		send_cmd(mk(OP_YIELD, 22'd99, 32'd0, 32'd0, 32'd100));
		send_cmd(mk(OP_DEREGISTER, 22'd99, 32'd0, 32'd0, 32'd100));
		send_cmd(mk(OP_YIELD, 22'd5, 32'd0, 32'd0, 32'd1000));
		send_cmd(mk(OP_TICK, 22'd0, 32'd0, 32'd0, 32'd1005));
		send_cmd(mk(OP_TICK, 22'd0, 32'd0, 32'd0, 32'd1010));
		send_cmd(mk(OP_YIELD, 22'd5, 32'd0, 32'd0, 32'd1020));
		send_cmd(mk(OP_YIELD, 22'd5, 32'd0, 32'd0, 32'd1015));
		send_cmd(mk(OP_YIELD, 22'h3FFFFF, 32'd0, 32'd0, 32'hFFFFFFF0));
		send_cmd(mk(OP_TICK, 22'h3FFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0));
		send_cmd(mk(OP_TICK, 22'd0, 32'd0, 32'd0, 32'd1040));
		send_cmd(mk(OP_DEREGISTER, 22'd5, 32'd0, 32'd0, 32'd1050));
		send_cmd(mk(OP_DEREGISTER, 22'h3FFFFF, 32'd0, 32'd0, 32'd1060));
		send_cmd(mk(OP_REGISTER, 22'd7, 32'd1, 32'd0, 32'd1070));

		repeat (200) send_cmd(rand_cmd());

		// limit zero rejects every register
		write_limit(14'd0);
		repeat (20) send_cmd(rand_cmd());

		write_limit(14'd10000);
		send_idle_pct = 86;
		recv_stall_pct = 37;
		repeat (220) send_cmd(rand_cmd());

		write_limit(14'($urandom_range(1, 9999)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (200) send_cmd(rand_cmd());
		cmd_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
sv/rmts_pkg.sv
sv/rmts_div.sv
sv/rmts_mem.sv
sv/rate_monotonic_task_scheduler_unit.sv
test/tb_rate_monotonic_task_scheduler_unit.sv
